[rtl/core/ntmr_pkg.sv]
// Package of the node table MAC registry: operation codes, item and result
// words, and the job word passed from the front to the back. No dependencies.
`default_nettype none
package ntmr_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam logic [15:0] FIRST_IDENT = 16'h0002;
    localparam logic [15:0] ROOT_ID_RST = 16'd1;
    localparam logic [15:0] HMI_ID_RST = 16'hFFFF;
    localparam logic [7:0] HMI_TYPE_RST = 8'd1;
    localparam int COUNT_OUT_W = 6;

    typedef enum logic [2:0] {
        OP_REGISTER  = 3'd0,
        OP_HEARTBEAT = 3'd1,
        OP_SET_STATUS = 3'd2,
        OP_QUERY     = 3'd3,
        OP_MARK_DIRTY = 3'd4,
        OP_NONE      = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        CFG_ROOT_ID  = 2'd0,
        CFG_HMI_ID   = 2'd1,
        CFG_HMI_TYPE = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_ONLINE  = 2'd0,
        ST_WARNING = 2'd1,
        ST_OFFLINE = 2'd2,
        ST_LOST    = 2'd3
    } t_status;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_EXEC = 1'b1
    } t_bk_state;

    typedef struct packed {
        logic [2:0]  operation;
        logic [47:0] mac_address;
        logic        reconnect;
        logic [7:0]  type_code;
        logic [7:0]  fw_major_in;
        logic [7:0]  fw_minor_in;
        logic [7:0]  fw_patch_in;
        logic [15:0] target_id;
        logic signed [7:0] rssi_in;
        logic [1:0]  new_status;
        logic [31:0] time_now_ms;
    } t_item;

    typedef struct packed {
        logic [15:0] given_id;
        logic        entry_found;
        logic [1:0]  entry_status;
        logic [7:0]  entry_type;
        logic        entry_is_hmi;
        logic [31:0] entry_last_seen;
        logic [5:0]  node_count;
        logic        table_dirty;
    } t_result;

    typedef struct packed {
        t_op   op;
        t_item item;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_q2b;

endpackage
`default_nettype wire

[rtl/core/ntmr_if.sv]
// Channel interfaces of the node table MAC registry: item, result and
// configuration write. Depends on ntmr_pkg.
`default_nettype none
interface ntmr_item_if;
    import ntmr_pkg::*;
    logic  valid;
    logic  ready;
    t_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ntmr_res_if;
    import ntmr_pkg::*;
    logic    valid;
    logic    ready;
    t_result data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ntmr_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

[rtl/core/node_table_mac_registry.sv]
// Top level of the node table MAC registry: front queue and back table.
// Depends on ntmr_pkg, ntmr_if, ntmr_front and ntmr_back.
//
// Item words enter on i_item, one result word per item leaves on o_res, and
// i_cfg writes root_id (index 0), hmi_id (1) and hmi_type_code (2); it is
// always ready. The front holds up to two items in a queue.
// The back handles one item at a time: in idle it compares the MAC and the ID
// against all table entries in parallel and registers the hits, and in exec
// it writes the entry back and loads the result register, before it takes
// the next item.
// A result waits in its register while the back already looks up the next
// item; the back stops in write-back when the result register is still full,
// and the front stops accepting once its queue is full.
// Reset clears all valid bits, the count, the dirty flag and the channels,
// sets the ID counter to two and restores the configuration registers.
`default_nettype none
module node_table_mac_registry #(
    parameter int TABLE_DEPTH = ntmr_pkg::TABLE_DEPTH_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    ntmr_item_if.sink    i_item,
    ntmr_cfg_if.sink     i_cfg,
    ntmr_res_if.source   o_res
);
    import ntmr_pkg::*;

    t_q2b q;
    logic pop;

    ntmr_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(i_item), .o_q(q), .i_pop(pop)
    );

    ntmr_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q(q), .o_pop(pop),
        .i_cfg(i_cfg), .o_res(o_res)
    );
endmodule
`default_nettype wire

[rtl/core/ntmr_front.sv]
// Front of the registry: accepts item words, decodes the operation and holds
// them in a two-entry queue for the back. Depends on ntmr_pkg and ntmr_if.
`default_nettype none
module ntmr_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    ntmr_item_if.sink        i_item,
    output ntmr_pkg::t_q2b   o_q,
    input  wire              i_pop
);
    import ntmr_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;
    t_job       in_job;
    logic       push;

    always_comb begin
        in_job.item = i_item.data;
        case (i_item.data.operation)
            OP_REGISTER:   in_job.op = OP_REGISTER;
            OP_HEARTBEAT:  in_job.op = OP_HEARTBEAT;
            OP_SET_STATUS: in_job.op = OP_SET_STATUS;
            OP_QUERY:      in_job.op = OP_QUERY;
            OP_MARK_DIRTY: in_job.op = OP_MARK_DIRTY;
            default:       in_job.op = OP_NONE;
        endcase
    end

    assign i_item.ready = (r_cnt != 2'd2);
    assign push = i_item.valid && i_item.ready;
    assign o_q.valid = (r_cnt != 2'd0);
    assign o_q.job = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !i_pop) n_cnt = r_cnt + 2'd1;
        else if (!push && i_pop) n_cnt = r_cnt - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= in_job;
    end
endmodule
`default_nettype wire

[rtl/core/ntmr_back.sv]
// Back of the registry: the node table, the lookup and write-back sequencer,
// the configuration registers and the result register. Depends on ntmr_pkg, ntmr_if.
`default_nettype none
module ntmr_back #(
    parameter int TABLE_DEPTH = ntmr_pkg::TABLE_DEPTH_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  ntmr_pkg::t_q2b   i_q,
    output logic             o_pop,
    ntmr_cfg_if.sink         i_cfg,
    ntmr_res_if.source       o_res
);
    import ntmr_pkg::*;

    localparam int SW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [TABLE_DEPTH-1:0] r_valid;
    logic [47:0] r_mac  [TABLE_DEPTH];
    logic [15:0] r_id   [TABLE_DEPTH];
    logic [7:0]  r_kind [TABLE_DEPTH];
    logic [1:0]  r_stat [TABLE_DEPTH];
    logic [31:0] r_seen [TABLE_DEPTH];
    logic [23:0] r_fw   [TABLE_DEPTH];
    logic [7:0]  r_rssi [TABLE_DEPTH];

    logic [15:0] r_next, r_root, r_hmi;
    logic [7:0]  r_hmi_type;
    logic [CW-1:0] r_count;
    logic        r_dirty;
    t_bk_state   r_state, n_state;

    t_job        r_job;
    logic        r_mac_hit, r_id_hit, r_free_hit;
    logic [SW-1:0] r_mac_slot, r_id_slot, r_free_slot;

    logic        r_ovalid;
    t_result     r_out;

    logic [TABLE_DEPTH-1:0] mac_vec, id_vec, free_vec;
    logic [SW-1:0] mac_slot, id_slot, free_slot;
    logic        out_free, do_exec, take;
    logic [15:0] skip_id;

    logic        wr_en, wr_new, wr_full;
    logic [SW-1:0] wr_slot;
    logic [1:0]  wr_stat;
    logic [7:0]  wr_kind;
    logic        set_dirty;
    t_result     res;
    logic [8:0]  cnt_ext;

    function automatic logic [SW-1:0] lowest(input logic [TABLE_DEPTH-1:0] v);
        logic [SW-1:0] idx;
        idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (v[i]) idx = SW'(i);
        end
        return idx;
    endfunction

    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            mac_vec[i]  = r_valid[i] && (r_mac[i] == i_q.job.item.mac_address);
            id_vec[i]   = r_valid[i] && (r_id[i] == i_q.job.item.target_id);
            free_vec[i] = !r_valid[i];
        end
        mac_slot  = lowest(mac_vec);
        id_slot   = lowest(id_vec);
        free_slot = lowest(free_vec);
    end

    always_comb begin
        skip_id = r_next;
        for (int k = 0; k < 3; k++) begin
            if (skip_id == r_root || skip_id == r_hmi) skip_id = skip_id + 16'd1;
        end
    end

    assign out_free = !r_ovalid || o_res.ready;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_state = r_state;
        take = 1'b0;
        do_exec = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_q.valid) begin
                    take = 1'b1;
                    n_state = BK_EXEC;
                end
            end
            BK_EXEC: begin
                if (out_free) begin
                    do_exec = 1'b1;
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
        o_pop = take;
    end

    always_comb begin
        wr_en = 1'b0;
        wr_new = 1'b0;
        wr_full = 1'b0;
        wr_slot = r_id_slot;
        wr_stat = r_stat[r_id_slot];
        wr_kind = r_kind[r_id_slot];
        set_dirty = 1'b0;
        res = '0;
        case (r_job.op)
            OP_REGISTER: begin
                wr_stat = ST_ONLINE;
                if (r_mac_hit) begin
                    wr_slot = r_mac_slot;
                    wr_en = 1'b1;
                    wr_full = !r_job.item.reconnect;
                    wr_kind = r_job.item.reconnect ? r_kind[r_mac_slot]
                                                   : r_job.item.type_code;
                    res.given_id = r_id[r_mac_slot];
                end else if (r_free_hit) begin
                    wr_slot = r_free_slot;
                    wr_en = 1'b1;
                    wr_new = 1'b1;
                    wr_full = 1'b1;
                    wr_kind = r_job.item.type_code;
                    res.given_id = skip_id;
                end
                set_dirty = wr_en;
                res.entry_found = wr_en;
            end
            OP_HEARTBEAT: begin
                if (r_id_hit) begin
                    wr_en = 1'b1;
                    if (r_stat[r_id_slot] inside {ST_WARNING, ST_OFFLINE})
                        wr_stat = ST_ONLINE;
                end
                res.entry_found = r_id_hit;
            end
            OP_SET_STATUS: begin
                if (r_id_hit) begin
                    wr_stat = r_job.item.new_status;
                    set_dirty = 1'b1;
                end
                res.entry_found = r_id_hit;
            end
            OP_QUERY: res.entry_found = r_id_hit;
            OP_MARK_DIRTY: set_dirty = 1'b1;
            default: ;
        endcase
        if (res.entry_found) begin
            res.entry_status = wr_stat;
            res.entry_type = wr_kind;
            res.entry_is_hmi = (wr_kind == r_hmi_type);
            res.entry_last_seen = (wr_en) ? r_job.item.time_now_ms : r_seen[wr_slot];
        end
        cnt_ext = 9'(r_count) + 9'(wr_new);
        res.node_count = (cnt_ext > 9'd63) ? 6'd63 : cnt_ext[5:0];
        res.table_dirty = r_dirty || set_dirty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_valid <= '0;
            r_next <= FIRST_IDENT;
            r_count <= '0;
            r_dirty <= 1'b0;
            r_ovalid <= 1'b0;
            r_root <= ROOT_ID_RST;
            r_hmi <= HMI_ID_RST;
            r_hmi_type <= HMI_TYPE_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_ROOT_ID:  r_root <= i_cfg.wdata;
                    CFG_HMI_ID:   r_hmi <= i_cfg.wdata;
                    CFG_HMI_TYPE: r_hmi_type <= i_cfg.wdata[7:0];
                    default: ;
                endcase
            end
            if (o_res.ready) r_ovalid <= 1'b0;
            if (do_exec) begin
                r_ovalid <= 1'b1;
                if (set_dirty) r_dirty <= 1'b1;
                if (wr_new) begin
                    r_valid[wr_slot] <= 1'b1;
                    r_count <= r_count + CW'(1);
                    r_next <= skip_id + 16'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_job <= i_q.job;
            r_mac_hit <= |mac_vec;
            r_id_hit <= |id_vec;
            r_free_hit <= |free_vec;
            r_mac_slot <= mac_slot;
            r_id_slot <= id_slot;
            r_free_slot <= free_slot;
        end
        if (do_exec) begin
            r_out <= res;
            if (wr_en || (r_job.op == OP_SET_STATUS && r_id_hit)) begin
                r_stat[wr_slot] <= wr_stat;
            end
            if (wr_en) r_seen[wr_slot] <= r_job.item.time_now_ms;
            if (r_job.op == OP_HEARTBEAT && wr_en) r_rssi[wr_slot] <= r_job.item.rssi_in;
            if (wr_new) begin
                r_id[wr_slot] <= skip_id;
                r_rssi[wr_slot] <= 8'd0;
            end
            if (wr_full) begin
                r_mac[wr_slot] <= r_job.item.mac_address;
                r_kind[wr_slot] <= r_job.item.type_code;
                r_fw[wr_slot] <= {r_job.item.fw_major_in, r_job.item.fw_minor_in,
                                  r_job.item.fw_patch_in};
            end
        end
    end

    assign o_res.valid = r_ovalid;
    assign o_res.data = r_out;
endmodule
`default_nettype wire

[bench/ntmr_checker.sv]
`timescale 1ns / 100ps
// Checker of the node table MAC registry: watches the item, configuration and
// result channels, keeps its own copy of the node table and compares results.
// Depends on ntmr_pkg and ntmr_if.
module ntmr_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    ntmr_item_if        item_bus,
    ntmr_cfg_if         cfg_bus,
    ntmr_res_if         res_bus,
    output int          o_fail_count,
    output int          o_pending
);
    import ntmr_pkg::*;

    localparam int DEPTH = TABLE_DEPTH_DEF;

    logic [15:0] root_id_q, hmi_id_q;
    logic [7:0]  hmi_type_q;
    logic        node_valid [DEPTH];
    logic [47:0] node_mac   [DEPTH];
    logic [15:0] node_ident [DEPTH];
    logic [7:0]  node_kind  [DEPTH];
    t_status     node_state [DEPTH];
    logic [31:0] node_seen  [DEPTH];
    logic [15:0] ident_counter;
    logic [5:0]  node_total;
    logic        dirty_q;
    t_result     expected_words [$];

    function automatic int find_mac(logic [47:0] mac);
        for (int i = 0; i < DEPTH; i++)
            if (node_valid[i] && node_mac[i] == mac) return i;
        return -1;
    endfunction

    function automatic int find_ident(logic [15:0] ident);
        for (int i = 0; i < DEPTH; i++)
            if (node_valid[i] && node_ident[i] == ident) return i;
        return -1;
    endfunction

    function automatic int find_free();
        for (int i = 0; i < DEPTH; i++)
            if (!node_valid[i]) return i;
        return -1;
    endfunction

    task automatic clear_table();
        root_id_q = ROOT_ID_RST;
        hmi_id_q = HMI_ID_RST;
        hmi_type_q = HMI_TYPE_RST;
        for (int i = 0; i < DEPTH; i++) node_valid[i] = 1'b0;
        ident_counter = FIRST_IDENT;
        node_total = '0;
        dirty_q = 1'b0;
        expected_words.delete();
    endtask

    task automatic predict_word(input t_item it);
        int slot;
        t_result r;
        slot = -1;
        r = '0;
        case (it.operation)
            OP_REGISTER: begin
                slot = find_mac(it.mac_address);
                if (slot >= 0 && it.reconnect) begin
                    node_state[slot] = ST_ONLINE;
                    node_seen[slot] = it.time_now_ms;
                    dirty_q = 1'b1;
                end else begin
                    if (slot < 0) begin
                        slot = find_free();
                        if (slot >= 0) begin
                            for (int k = 0; k < 3; k++)
                                if (ident_counter == root_id_q || ident_counter == hmi_id_q)
                                    ident_counter++;
                            node_ident[slot] = ident_counter;
                            ident_counter++;
                            node_valid[slot] = 1'b1;
                            node_total++;
                        end
                    end
                    if (slot >= 0) begin
                        node_mac[slot] = it.mac_address;
                        node_kind[slot] = it.type_code;
                        node_state[slot] = ST_ONLINE;
                        node_seen[slot] = it.time_now_ms;
                        dirty_q = 1'b1;
                    end
                end
                if (slot >= 0) r.given_id = node_ident[slot];
            end
            OP_HEARTBEAT: begin
                slot = find_ident(it.target_id);
                if (slot >= 0) begin
                    node_seen[slot] = it.time_now_ms;
                    if (node_state[slot] == ST_WARNING || node_state[slot] == ST_OFFLINE)
                        node_state[slot] = ST_ONLINE;
                end
            end
            OP_SET_STATUS: begin
                slot = find_ident(it.target_id);
                if (slot >= 0) begin
                    node_state[slot] = t_status'(it.new_status);
                    dirty_q = 1'b1;
                end
            end
            OP_QUERY: slot = find_ident(it.target_id);
            OP_MARK_DIRTY: dirty_q = 1'b1;
            default: ;
        endcase
        if (slot >= 0) begin
            r.entry_found = 1'b1;
            r.entry_status = node_state[slot];
            r.entry_type = node_kind[slot];
            r.entry_is_hmi = (node_kind[slot] == hmi_type_q);
            r.entry_last_seen = node_seen[slot];
        end
        r.node_count = node_total;
        r.table_dirty = dirty_q;
        expected_words.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("field %s: expected %0h, actual %0h", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    task automatic compare_word(input t_result act);
        t_result exp_w;
        if (expected_words.size() == 0) begin
            $error("result word with no expectation waiting");
            o_fail_count++;
        end else begin
            exp_w = expected_words.pop_front();
            check_field("given_id", 32'(exp_w.given_id), 32'(act.given_id));
            check_field("entry_found", 32'(exp_w.entry_found), 32'(act.entry_found));
            check_field("entry_status", 32'(exp_w.entry_status), 32'(act.entry_status));
            check_field("entry_type", 32'(exp_w.entry_type), 32'(act.entry_type));
            check_field("entry_is_hmi", 32'(exp_w.entry_is_hmi), 32'(act.entry_is_hmi));
            check_field("entry_last_seen", exp_w.entry_last_seen, act.entry_last_seen);
            check_field("node_count", 32'(exp_w.node_count), 32'(act.node_count));
            check_field("table_dirty", 32'(exp_w.table_dirty), 32'(act.table_dirty));
        end
    endtask

    initial begin
        o_fail_count = 0;
        clear_table();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_table();
        end else begin
            if (cfg_bus.valid && cfg_bus.ready) begin
                case (cfg_bus.index)
                    CFG_ROOT_ID: root_id_q = cfg_bus.wdata;
                    CFG_HMI_ID: hmi_id_q = cfg_bus.wdata;
                    CFG_HMI_TYPE: hmi_type_q = cfg_bus.wdata[7:0];
                    default: ;
                endcase
            end
            if (res_bus.valid && res_bus.ready) compare_word(res_bus.data);
            if (item_bus.valid && item_bus.ready) predict_word(item_bus.data);
        end
        o_pending = expected_words.size();
    end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// Top of the node table MAC registry testbench: clock, reset, directed and
// random stimulus and the verdict. Depends on ntmr_pkg, ntmr_if and ntmr_checker.
module tb_top;
    import ntmr_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count, pending, cycle_count;
    logic item_gaps = 1'b1, res_gaps = 1'b1;
    logic [47:0] mac_pool [40];

    ntmr_item_if item_bus ();
    ntmr_cfg_if  cfg_bus ();
    ntmr_res_if  res_bus ();

    node_table_mac_registry u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_item(item_bus), .i_cfg(cfg_bus), .o_res(res_bus)
    );

    ntmr_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .item_bus(item_bus), .cfg_bus(cfg_bus), .res_bus(res_bus),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("[node_table_mac_registry] ERROR");
            $finish;
        end
    end

    always @(negedge i_clk)
        res_bus.ready <= !(res_gaps && $urandom_range(0, 99) < 21);

    task automatic send_word(input t_item it);
        @(negedge i_clk);
        while (item_gaps && $urandom_range(0, 99) < 21) begin
            item_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_bus.valid <= 1'b1;
        item_bus.data <= it;
        do @(posedge i_clk); while (!item_bus.ready);
    endtask

    task automatic drain();
        @(negedge i_clk);
        item_bus.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] value);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.wdata <= value;
        do @(posedge i_clk); while (!cfg_bus.ready);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    function automatic t_item make_word(input logic [2:0] op, input logic [47:0] mac,
                                        input logic [15:0] target);
        t_item it;
        it.operation = op;
        it.mac_address = mac;
        it.reconnect = 1'($urandom_range(0, 1));
        it.type_code = 8'($urandom);
        it.fw_major_in = 8'($urandom);
        it.fw_minor_in = 8'($urandom);
        it.fw_patch_in = 8'($urandom);
        it.target_id = target;
        it.rssi_in = 8'($urandom);
        it.new_status = 2'($urandom);
        it.time_now_ms = $urandom;
        return it;
    endfunction

    function automatic t_item random_word();
        int pick;
        logic [2:0] op;
        logic [47:0] mac;
        logic [15:0] target;
        pick = $urandom_range(0, 99);
        if (pick < 30) op = OP_REGISTER;
        else if (pick < 55) op = OP_HEARTBEAT;
        else if (pick < 70) op = OP_SET_STATUS;
        else if (pick < 90) op = OP_QUERY;
        else if (pick < 95) op = OP_MARK_DIRTY;
        else op = 3'($urandom_range(5, 7));
        mac = ($urandom_range(0, 99) < 85) ? mac_pool[$urandom_range(0, 39)]
                                           : 48'({$urandom, $urandom});
        target = ($urandom_range(0, 99) < 80) ? 16'($urandom_range(0, 40))
                                              : 16'($urandom);
        return make_word(op, mac, target);
    endfunction

    initial begin
        t_item it;
        item_bus.valid = 1'b0;
        item_bus.data = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = CFG_ROOT_ID;
        cfg_bus.wdata = '0;
        res_bus.ready = 1'b0;
        cycle_count = 0;
        foreach (mac_pool[i]) mac_pool[i] = 48'({$urandom, $urandom});
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(CFG_ROOT_ID, 16'd2);
        write_reg(CFG_HMI_ID, 16'd3);
        write_reg(CFG_HMI_TYPE, 16'd0);

        // Reserved identifiers two and three are skipped, so the first node gets four.
        it = make_word(OP_REGISTER, 48'h0, 16'd0);
        it.reconnect = 1'b0; it.type_code = 8'h00; it.time_now_ms = 32'h0;
        send_word(it);
        it = make_word(OP_REGISTER, 48'hFFFF_FFFF_FFFF, 16'd0);
        it.reconnect = 1'b1; it.type_code = 8'hFF; it.time_now_ms = 32'hFFFF_FFFF;
        send_word(it);
        it = make_word(OP_REGISTER, 48'h0, 16'd0);
        it.reconnect = 1'b1;
        send_word(it);
        it = make_word(OP_REGISTER, 48'hFFFF_FFFF_FFFF, 16'd0);
        it.reconnect = 1'b0;
        send_word(it);
        for (int s = 0; s < 4; s++) begin
            it = make_word(OP_SET_STATUS, 48'h0, 16'd4);
            it.new_status = 2'(s);
            send_word(it);
            it = make_word(OP_HEARTBEAT, 48'h0, 16'd4);
            it.rssi_in = (s == 0) ? -8'sd128 : 8'sd127;
            send_word(it);
        end
        send_word(make_word(OP_QUERY, 48'h0, 16'd5));
        send_word(make_word(OP_QUERY, 48'h0, 16'hFFFF));
        send_word(make_word(OP_HEARTBEAT, 48'h0, 16'd0));
        send_word(make_word(OP_SET_STATUS, 48'h0, 16'd77));
        send_word(make_word(OP_MARK_DIRTY, 48'h0, 16'd0));
        for (int op = 5; op < 8; op++) send_word(make_word(3'(op), 48'h0, 16'd4));
        drain();

        write_reg(CFG_ROOT_ID, 16'hFFFF);
        write_reg(CFG_HMI_ID, 16'd0);
        write_reg(CFG_HMI_TYPE, 16'hFF);
        for (int n = 0; n < 450; n++) begin
            item_gaps = !(n >= 150 && n < 300);
            res_gaps = item_gaps;
            if (n == 350) begin
                drain();
            end
            send_word(random_word());
        end
        drain();

        write_reg(CFG_ROOT_ID, 16'($urandom));
        write_reg(CFG_HMI_ID, 16'($urandom));
        write_reg(CFG_HMI_TYPE, 16'($urandom_range(0, 255)));
        for (int n = 0; n < 480; n++) send_word(random_word());
        drain();

        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("[node_table_mac_registry] OK");
        else
            $display("[node_table_mac_registry] ERROR");
        $finish;
    end

endmodule
